// ===== rtl/lsob_pkg.sv =====
// Shared types, constants and sector geometry for the lidar sector occupancy binner.
// Used by lsob_tracker and lidar_sector_occupancy_binner_core; depends on nothing.
package lsob_pkg;

	localparam int NUM_SECTORS = 18;
	localparam int SECTOR_W    = 5;
	localparam int ANGLE_W     = 9;
	localparam int DIST_W      = 12;
	localparam int COUNT_W     = 8;
	localparam int CFG_IDX_W   = 2;

	localparam logic [ANGLE_W-1:0] FULL_TURN    = 9'd360;
	localparam logic [ANGLE_W:0]   SECTOR_SPAN  = 10'd20;
	localparam logic [SECTOR_W-1:0] LAST_SECTOR = 5'd17;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'd255;

	localparam logic [SECTOR_W-1:0] RST_CURRENT = 5'd4;
	localparam logic [SECTOR_W-1:0] RST_NEXT    = 5'd5;
	localparam logic [DIST_W-1:0]   RST_NEAR    = 12'd200;
	localparam logic [COUNT_W-1:0]  RST_THRESH  = 8'd5;
	localparam logic [DIST_W-1:0]   RST_MAX     = 12'd600;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NEAR_RANGE      = 2'd0,
		CFG_COUNT_THRESHOLD = 2'd1,
		CFG_MAX_RANGE       = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle_deg;
		logic [DIST_W-1:0]  distance_cm;
	} sample_t;

	typedef struct packed {
		logic                   in_sync;
		logic                   sector_closed;
		logic [SECTOR_W-1:0]    closed_sector;
		logic                   closed_occupied;
		logic [DIST_W-1:0]      closed_min_distance;
		logic [NUM_SECTORS-1:0] occupancy_map;
	} result_t;

	typedef struct packed {
		logic [DIST_W-1:0]  near_range;
		logic [COUNT_W-1:0] count_threshold;
		logic [DIST_W-1:0]  max_range;
	} cfg_t;

	// First bearing of each sector; sector 0 starts at 270 and sector 4 wraps through 0.
	function automatic logic [ANGLE_W-1:0] sector_lo(input logic [SECTOR_W-1:0] s);
		logic [ANGLE_W-1:0] lo;
		unique case (s)
			5'd0:    lo = 9'd270;
			5'd1:    lo = 9'd290;
			5'd2:    lo = 9'd310;
			5'd3:    lo = 9'd330;
			5'd4:    lo = 9'd350;
			5'd5:    lo = 9'd10;
			5'd6:    lo = 9'd30;
			5'd7:    lo = 9'd50;
			5'd8:    lo = 9'd70;
			5'd9:    lo = 9'd90;
			5'd10:   lo = 9'd110;
			5'd11:   lo = 9'd130;
			5'd12:   lo = 9'd150;
			5'd13:   lo = 9'd170;
			5'd14:   lo = 9'd190;
			5'd15:   lo = 9'd210;
			5'd16:   lo = 9'd230;
			5'd17:   lo = 9'd250;
			default: lo = 9'd0;
		endcase
		return lo;
	endfunction

	// Bearing falls in [lo, lo+20) modulo one turn; angle is below 360 here.
	function automatic logic angle_in_sector(input logic [ANGLE_W-1:0] angle,
			input logic [SECTOR_W-1:0] s);
		logic [ANGLE_W-1:0] lo;
		logic [ANGLE_W:0]   off;
		lo = sector_lo(s);
		if (angle >= lo) begin
			off = {1'b0, angle} - {1'b0, lo};
		end else begin
			off = {1'b0, angle} + {1'b0, FULL_TURN} - {1'b0, lo};
		end
		return off < SECTOR_SPAN;
	endfunction

endpackage

// ===== rtl/lsob_tracker.sv =====
// Sector tracking state and the per-sample update: minimum, near count, occupancy bits.
// Depends on lsob_pkg.
module lsob_tracker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  lsob_pkg::sample_t sample,
	input  lsob_pkg::cfg_t    cfg,
	output lsob_pkg::result_t result
);
	import lsob_pkg::*;

	logic [SECTOR_W-1:0]    current_q;
	logic [SECTOR_W-1:0]    next_q;
	logic [DIST_W-1:0]      min_q;
	logic [COUNT_W-1:0]     count_q;
	logic [NUM_SECTORS-1:0] occ_q;

	logic [SECTOR_W-1:0]    current_d;
	logic [SECTOR_W-1:0]    next_d;
	logic [DIST_W-1:0]      min_d;
	logic [COUNT_W-1:0]     count_d;
	logic [NUM_SECTORS-1:0] occ_d;

	logic angle_ok;
	logic hit_cur;
	logic hit_next;
	logic dist_pos;
	logic verdict;

	always_comb begin
		angle_ok = (sample.angle_deg != '0) && (sample.angle_deg < FULL_TURN);
		hit_cur  = angle_ok && angle_in_sector(sample.angle_deg, current_q);
		hit_next = angle_ok && !hit_cur && angle_in_sector(sample.angle_deg, next_q);
		dist_pos = sample.distance_cm != '0;
		verdict  = count_q > cfg.count_threshold;

		current_d = current_q;
		next_d    = next_q;
		min_d     = min_q;
		count_d   = count_q;
		occ_d     = occ_q;

		if (hit_cur) begin
			if (dist_pos && sample.distance_cm <= cfg.max_range) begin
				if (sample.distance_cm < min_q) begin
					min_d = sample.distance_cm;
				end
				if (sample.distance_cm <= cfg.near_range && count_q != COUNT_MAX) begin
					count_d = count_q + 1'b1;
				end
			end
		end else if (hit_next) begin
			occ_d[current_q] = verdict;
			current_d = next_q;
			next_d    = (next_q == LAST_SECTOR) ? '0 : next_q + 1'b1;
			// reload, then fold the sample with the near test alone
			min_d   = cfg.max_range;
			count_d = '0;
			if (dist_pos && sample.distance_cm <= cfg.near_range) begin
				if (sample.distance_cm < cfg.max_range) begin
					min_d = sample.distance_cm;
				end
				count_d = COUNT_W'(1);
			end
		end

		result.in_sync             = !angle_ok || hit_cur || hit_next;
		result.sector_closed       = hit_next;
		result.closed_sector       = hit_next ? current_q : '0;
		result.closed_occupied     = hit_next && verdict;
		result.closed_min_distance = hit_next ? min_q : '0;
		result.occupancy_map       = occ_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_q <= RST_CURRENT;
			next_q    <= RST_NEXT;
			min_q     <= RST_MAX;
			count_q   <= '0;
			occ_q     <= '0;
		end else if (en) begin
			current_q <= current_d;
			next_q    <= next_d;
			min_q     <= min_d;
			count_q   <= count_d;
			occ_q     <= occ_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_next_follows: assert property (@(posedge clk) disable iff (!arst_n)
		next_q == ((current_q == LAST_SECTOR) ? '0 : current_q + 1'b1))
		else $error("next sector does not follow current sector");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(count_q) && $stable(min_q) && $stable(occ_q) && $stable(current_q))
		else $error("tracker state moved without a sample");

	a_close_advances: assert property (@(posedge clk) disable iff (!arst_n)
		en && hit_next |=> current_q == $past(next_q) && count_q <= COUNT_W'(1))
		else $error("sector close did not advance and clear");
`endif

endmodule

// ===== rtl/lidar_sector_occupancy_binner_core.sv =====
// Top level of the lidar sector occupancy binner: sample register, result register,
// configuration registers and handshakes. Depends on lsob_pkg and lsob_tracker.
//
// Takes one lidar sample (bearing, range) per word and returns one result word per
// sample, in order. A new sample is accepted every cycle while samples are not stalled;
// each sample waits in the sample register, where the sector compare and the state
// update run, and its result is then held in the result register. The single
// registered compare-and-update path of the sector tracker sets this rate. The block
// stalls samples only when both the sample and result registers are full and the result
// is stalled. Configuration writes are always ready and take effect at once; write them
// only while no sample is in flight. Writes to an unused index are ignored.
module lidar_sector_occupancy_binner_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  lsob_pkg::sample_t               sample,
	output logic                            result_valid,
	input  logic                            result_stall,
	output lsob_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lsob_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lsob_pkg::DIST_W-1:0]     cfg_data
);
	import lsob_pkg::*;

	sample_t sample_s1;
	logic    valid_s1;
	result_t result_q;
	logic    result_valid_q;
	cfg_t    cfg_q;
	result_t step_res;
	logic    advance;
	logic    accept;

	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = valid_s1 && !advance;
	assign accept       = sample_valid && !sample_stall;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	lsob_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.sample (sample_s1),
		.cfg    (cfg_q),
		.result (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// payload registers: load on accept / advance only
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
		end
		if (advance) begin
			result_q <= step_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.near_range      <= RST_NEAR;
			cfg_q.count_threshold <= RST_THRESH;
			cfg_q.max_range       <= RST_MAX;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_NEAR_RANGE:      cfg_q.near_range      <= cfg_data;
				CFG_COUNT_THRESHOLD: cfg_q.count_threshold <= cfg_data[COUNT_W-1:0];
				CFG_MAX_RANGE:       cfg_q.max_range       <= cfg_data;
				default: ;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> valid_s1 && result_valid_q && result_stall)
		else $error("sample stalled with room in the pipeline");

	a_unclosed_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.sector_closed |->
			result.closed_sector == '0 && !result.closed_occupied &&
			result.closed_min_distance == '0)
		else $error("closed fields set on a word that closed nothing");

	a_closed_in_sync: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.sector_closed |->
			result.in_sync && result.occupancy_map[result.closed_sector] ==
			result.closed_occupied)
		else $error("closed sector verdict disagrees with occupancy map");

	a_result_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(valid_s1))
		else $error("result word without a registered sample");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for lidar_sector_occupancy_binner_core: tracks the sector state in
// its own predictor and checks every result word in order. Depends on lsob_pkg and the RTL.
module tb;
	import lsob_pkg::*;

	localparam int FIRST_BEARING = 270;
	localparam int SPAN_DEG      = 20;
	localparam int TURN_DEG      = 360;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic sample_valid;
	logic sample_stall;
	sample_t sample;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIST_W-1:0] cfg_data;

	lidar_sector_occupancy_binner_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// predicted sector tracker state and register copies
	logic [SECTOR_W-1:0]    cur_sec = RST_CURRENT;
	logic [SECTOR_W-1:0]    nxt_sec = RST_NEXT;
	logic [DIST_W-1:0]      sec_min = RST_MAX;
	logic [COUNT_W-1:0]     near_cnt = '0;
	logic [NUM_SECTORS-1:0] occ_bits = '0;
	logic [DIST_W-1:0]      near_rng = RST_NEAR;
	logic [COUNT_W-1:0]     thresh = RST_THRESH;
	logic [DIST_W-1:0]      max_rng = RST_MAX;

	result_t pending_results[$];
	int n_fail = 0;
	int n_items = 0;
	int n_results = 0;
	int n_closed = 0;
	int n_occupied = 0;
	int n_unsync = 0;
	int cycles = 0;
	bit idling_on = 1'b1;
	bit feed_live = 1'b0;

	function automatic bit bearing_in_sector(input int unsigned ang, input int unsigned sec);
		int unsigned lo;
		int unsigned off;
		lo = (FIRST_BEARING + SPAN_DEG * (sec % NUM_SECTORS)) % TURN_DEG;
		off = (ang + TURN_DEG - lo) % TURN_DEG;
		return off < SPAN_DEG;
	endfunction

	// Advance the predicted tracker by one sample and return the result word it yields.
	function automatic result_t bin_sample(input logic [ANGLE_W-1:0] ang,
			input logic [DIST_W-1:0] rng);
		result_t r;
		r = '0;
		r.in_sync = 1'b1;
		if (ang > 0 && ang < TURN_DEG) begin
			if (bearing_in_sector(ang, cur_sec)) begin
				if (rng > 0 && rng <= max_rng) begin
					if (rng < sec_min)
						sec_min = rng;
					if (rng <= near_rng && near_cnt < COUNT_MAX)
						near_cnt++;
				end
			end else if (bearing_in_sector(ang, nxt_sec)) begin
				r.sector_closed = 1'b1;
				r.closed_sector = SECTOR_W'(cur_sec % NUM_SECTORS);
				r.closed_occupied = near_cnt > thresh;
				r.closed_min_distance = sec_min;
				occ_bits[cur_sec % NUM_SECTORS] = r.closed_occupied;
				sec_min = max_rng;
				near_cnt = '0;
				cur_sec = SECTOR_W'(nxt_sec % NUM_SECTORS);
				nxt_sec = SECTOR_W'((cur_sec + 1) % NUM_SECTORS);
				// the new sector only sees the near test here
				if (rng > 0 && rng <= near_rng) begin
					if (rng < sec_min)
						sec_min = rng;
					if (near_cnt < COUNT_MAX)
						near_cnt++;
				end
			end else begin
				r.in_sync = 1'b0;
			end
		end
		r.occupancy_map = occ_bits;
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		if (!idling_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [ANGLE_W-1:0] bearing_of(input int unsigned sec);
		return ANGLE_W'((FIRST_BEARING + SPAN_DEG * (sec % NUM_SECTORS)
			+ $urandom_range(0, SPAN_DEG - 1)) % TURN_DEG);
	endfunction

	function automatic logic [DIST_W-1:0] pick_range();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 45)
			return DIST_W'($urandom_range(1, near_rng));
		if (r < 58)
			return near_rng;
		if (r < 70)
			return max_rng;
		if (r < 84)
			return DIST_W'($urandom_range(near_rng, max_rng));
		if (r < 93)
			return DIST_W'($urandom_range(0, 4095));
		return '1;
	endfunction

	// Present one sample word, hold it until taken, then record its predicted result.
	task automatic send_sample(input logic [ANGLE_W-1:0] ang, input logic [DIST_W-1:0] rng);
		int gap;
		sample_valid <= 1'b1;
		sample <= '{angle_deg: ang, distance_cm: rng};
		feed_live = 1'b1;
		do
			@(posedge clk);
		while (sample_stall);
		pending_results.push_back(bin_sample(ang, rng));
		n_items++;
		gap = idle_len();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			feed_live = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop the feed and let every outstanding result drain out.
	task automatic wait_idle();
		if (feed_live) begin
			sample_valid <= 1'b0;
			feed_live = 1'b0;
		end
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIST_W-1:0] data);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_NEAR_RANGE:      near_rng = data;
			CFG_COUNT_THRESHOLD: thresh = data[COUNT_W-1:0];
			CFG_MAX_RANGE:       max_rng = data;
			default: ;
		endcase
	endtask

	task automatic set_ranges(input logic [DIST_W-1:0] near, input logic [DIST_W-1:0] thr,
			input logic [DIST_W-1:0] maxr);
		write_reg(CFG_NEAR_RANGE, near);
		write_reg(CFG_COUNT_THRESHOLD, thr);
		write_reg(CFG_MAX_RANGE, maxr);
	endtask

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_fail++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing pending: %h", result);
				n_fail++;
			end else begin
				want = pending_results.pop_front();
				check_field("in_sync", want.in_sync, result.in_sync);
				check_field("sector_closed", want.sector_closed, result.sector_closed);
				check_field("closed_sector", want.closed_sector, result.closed_sector);
				check_field("closed_occupied", want.closed_occupied, result.closed_occupied);
				check_field("closed_min_distance", want.closed_min_distance,
					result.closed_min_distance);
				check_field("occupancy_map", want.occupancy_map, result.occupancy_map);
				n_results++;
				n_closed += want.sector_closed;
				n_occupied += want.closed_occupied;
				n_unsync += !want.in_sync;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver back-pressure: runs of free cycles, short stalls and the odd long one.
	initial begin
		int r;
		int len;
		logic hold;
		result_stall <= 1'b0;
		forever begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				hold = 1'b0;
				len = $urandom_range(1, 20);
			end else if (r < 95) begin
				hold = 1'b1;
				len = $urandom_range(1, 3);
			end else begin
				hold = 1'b1;
				len = $urandom_range(10, 40);
			end
			@(posedge clk);
			result_stall <= hold & idling_on;
			repeat (len - 1) @(posedge clk);
		end
	end

	task automatic test_reset_state();
		send_sample(9'd350, 12'd0);
		send_sample(9'd359, 12'd600);
		send_sample(9'd0, 12'd100);
		send_sample(9'd9, 12'd601);
		send_sample(9'd360, 12'd5);
		send_sample(9'd511, 12'd5);
		send_sample(9'd180, 12'd50);
		send_sample(9'd349, 12'd1);
		send_sample(9'd5, 12'd4095);
		send_sample(9'd10, 12'd1);
		wait_idle();
	endtask

	task automatic test_range_edges();
		set_ranges(12'd0, 12'd0, 12'd0);
		send_sample(9'd20, 12'd1);
		send_sample(9'd29, 12'd0);
		send_sample(9'd30, 12'd0);
		set_ranges(12'd4095, 12'd255, 12'd4095);
		send_sample(9'd49, 12'd4095);
		send_sample(9'd50, 12'd4095);
		send_sample(9'd70, 12'd4095);
		set_ranges(12'd100, 12'd0, 12'd200);
		send_sample(9'd75, 12'd100);
		send_sample(9'd76, 12'd101);
		send_sample(9'd77, 12'd200);
		send_sample(9'd78, 12'd201);
		send_sample(9'd90, 12'd150);
		send_sample(9'd109, 12'd0);
		send_sample(9'd110, 12'd99);
		wait_idle();
	endtask

	// Push the near-hit count past its ceiling, once just over and once at the threshold.
	task automatic test_count_ceiling();
		set_ranges(12'd4095, 12'd254, 12'd4095);
		repeat (260) send_sample(bearing_of(cur_sec), DIST_W'($urandom_range(1, 4095)));
		wait_idle();
		send_sample(bearing_of(nxt_sec), 12'd7);
		write_reg(CFG_COUNT_THRESHOLD, 12'd255);
		repeat (258) send_sample(bearing_of(cur_sec), DIST_W'($urandom_range(1, 4095)));
		wait_idle();
		send_sample(bearing_of(nxt_sec), 12'd0);
		wait_idle();
	endtask

	task automatic test_spare_index();
		write_reg(CFG_SPARE_INDEX, DIST_W'($urandom_range(0, 4095)));
		write_reg(CFG_COUNT_THRESHOLD, 12'hF03);
		send_sample(bearing_of(cur_sec), near_rng);
		send_sample(bearing_of(nxt_sec), 12'd1);
		wait_idle();
	endtask

	// Mostly in-order sweeps; a share of out-of-sync, ignored and raw bearings mixed in.
	task automatic sweep_phase(input int n, input int pct_next);
		int counted;
		int r;
		logic [ANGLE_W-1:0] ang;
		counted = 0;
		while (counted < n) begin
			r = $urandom_range(0, 99);
			if (r < pct_next)
				ang = bearing_of(nxt_sec);
			else if (r < 90)
				ang = bearing_of(cur_sec);
			else if (r < 95)
				ang = bearing_of(cur_sec + $urandom_range(2, NUM_SECTORS - 1));
			else if (r < 98)
				ang = $urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(TURN_DEG, 511));
			else
				ang = ANGLE_W'($urandom_range(0, 511));
			send_sample(ang, pick_range());
			if (ang > 0 && ang < TURN_DEG)
				counted++;
		end
	endtask

	task automatic test_random_sweeps();
		for (int p = 0; p < 8; p++) begin
			idling_on = (p != 3);
			case (p)
				0: set_ranges(RST_NEAR, DIST_W'(RST_THRESH), RST_MAX);
				1: set_ranges(12'd0, 12'd0, 12'd0);
				2: set_ranges(12'd4095, 12'd255, 12'd4095);
				3: set_ranges(12'd4095, 12'd0, 12'd4095);
				4: set_ranges(12'd300, 12'd2, 12'd4095);
				5: set_ranges(DIST_W'($urandom_range(0, 4095)),
					DIST_W'($urandom_range(0, 10)), DIST_W'($urandom_range(0, 4095)));
				6: set_ranges(12'd4095, 12'd3, 12'd100);
				default: set_ranges(DIST_W'($urandom_range(0, 4095)),
					{4'($urandom), 8'($urandom_range(0, 12))},
					DIST_W'($urandom_range(0, 4095)));
			endcase
			sweep_phase(110, (p == 3) ? 30 : $urandom_range(5, 20));
		end
		idling_on = 1'b1;
		wait_idle();
	endtask

	initial begin
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_range_edges();
		test_count_ceiling();
		test_spare_index();
		test_random_sweeps();
		wait_idle();
		$display("Sent %0d samples and checked %0d result words in %0d cycles.",
			n_items, n_results, cycles);
		$display("Sectors closed: %0d (%0d occupied), out-of-sync samples: %0d.",
			n_closed, n_occupied, n_unsync);
		if (n_fail == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
